### src/vds_pkg.sv
// Shared types and constants for the volume divergence stencil.
// No dependencies; every other file in src except vds_ram refers to it by scoped names.
package vds_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIM_W       = 7;
    localparam int DEPTH_W     = 16;
    localparam int COMP_W      = 2;
    localparam int SCALE_W     = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + SCALE_W + 1;
    localparam int DIV_W       = 36;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // tuser code of an input beat
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOL_WIDTH  = 3'd0,
        REG_VOL_HEIGHT = 3'd1,
        REG_VOL_DEPTH  = 3'd2,
        REG_COMP_COUNT = 3'd3,
        REG_SCALE_X    = 3'd4,
        REG_SCALE_Y    = 3'd5,
        REG_SCALE_Z    = 3'd6
    } reg_idx_t;

    localparam logic [DIM_W-1:0]   RST_VOL_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_VOL_HEIGHT = 7'd64;
    localparam logic [DEPTH_W-1:0] RST_VOL_DEPTH  = 16'd64;
    localparam logic [COMP_W-1:0]  RST_COMP_COUNT = 2'd3;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd2048;

    // one history slot: voxel flag and the three components
    typedef struct packed {
        logic                       voxel;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } vox_t;

    // effective geometry after clamping
    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DEPTH_W-1:0] d;
        logic [COMP_W-1:0]  comps;
    } geom_t;

    typedef struct packed {
        logic [SCALE_W-1:0] x;
        logic [SCALE_W-1:0] y;
        logic [SCALE_W-1:0] z;
    } scale_t;

    // beat in flight toward the history reads
    typedef struct packed {
        logic valid;
        logic fire_ok;
    } pend_t;

    // result in flight toward the output
    typedef struct packed {
        logic valid;
        logic last;
    } res_ctl_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } diff_t;

    typedef struct packed {
        logic                    last;
        logic signed [DIV_W-1:0] div;
    } result_t;

endpackage

### src/vds_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module vds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### src/vds_addr.sv
// Input register, history write pointer, fill count and neighbor address generation.
// Depends on vds_pkg.
module vds_addr #(
    parameter int HIST_DEPTH = 8258,
    parameter int CNT_CAP    = 4162
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic                                  in_kind,
    input  logic signed [vds_pkg::SAMPLE_W-1:0]   in_x,
    input  logic signed [vds_pkg::SAMPLE_W-1:0]   in_y,
    input  logic signed [vds_pkg::SAMPLE_W-1:0]   in_z,
    input  vds_pkg::geom_t                        geom,
    output vds_pkg::pend_t                        pend,
    output vds_pkg::vox_t                         wr_vox,
    output logic [$clog2(HIST_DEPTH)-1:0]         waddr,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_ctr,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_nx,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_ny,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_py,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_nz,
    output logic [$clog2(HIST_DEPTH)-1:0]         ra_pz
);

    localparam int ADDR_W = $clog2(HIST_DEPTH);

    logic                              v1_reg;
    vds_pkg::vox_t                     vox1_reg;
    logic [2*vds_pkg::DIM_W-1:0]       wh_full;
    logic [ADDR_W-1:0]                 wh_reg;
    logic [ADDR_W-1:0]                 w_a;
    logic [ADDR_W-1:0]                 k_ctr, k_nx, k_ny, k_py, k_nz, k_pz;
    logic [ADDR_W-1:0]                 wptr_reg, wptr_next;
    logic [ADDR_W-1:0]                 cnt_reg, cnt_next, cnt_inc;
    logic                              fire_ok;
    vds_pkg::pend_t                    pend_reg;
    vds_pkg::vox_t                     vox2_reg;
    logic [ADDR_W-1:0]                 waddr_reg;
    logic [ADDR_W-1:0]                 ra_ctr_reg, ra_nx_reg, ra_ny_reg;
    logic [ADDR_W-1:0]                 ra_py_reg, ra_nz_reg, ra_pz_reg;

    // slot k beats behind p on the ring
    function automatic logic [ADDR_W-1:0] ring_back(input logic [ADDR_W-1:0] p,
                                                    input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0] r;
        r = p - k;
        if (p < k) begin
            r = r + ADDR_W'(HIST_DEPTH);
        end
        return r;
    endfunction

    assign wh_full = geom.w * geom.h;
    assign w_a     = ADDR_W'(geom.w);

    // distances from the newest slot to each tap
    assign k_nz  = w_a + ADDR_W'(1);
    assign k_ny  = wh_reg + ADDR_W'(1);
    assign k_nx  = wh_reg + w_a;
    assign k_ctr = wh_reg + w_a + ADDR_W'(1);
    assign k_py  = wh_reg + (w_a << 1) + ADDR_W'(1);
    assign k_pz  = (wh_reg << 1) + w_a + ADDR_W'(1);

    assign cnt_inc = (cnt_reg == ADDR_W'(CNT_CAP)) ? cnt_reg : cnt_reg + 1'b1;
    assign fire_ok = cnt_inc > k_ctr;

    always_comb begin
        wptr_next = wptr_reg;
        cnt_next  = cnt_reg;
        if (en && v1_reg) begin
            wptr_next = (wptr_reg == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            cnt_next  = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            pend_reg.valid <= 1'b0;
            wptr_reg       <= '0;
            cnt_reg        <= '0;
        end else begin
            wptr_reg <= wptr_next;
            cnt_reg  <= cnt_next;
            if (en) begin
                v1_reg         <= in_valid;
                pend_reg.valid <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wh_reg <= ADDR_W'(wh_full);
        if (en) begin
            // a flush tick occupies a slot as an all-zero non-voxel
            vox1_reg.voxel <= (in_kind != vds_pkg::KIND_FLUSH);
            vox1_reg.x     <= (in_kind == vds_pkg::KIND_FLUSH) ? '0 : in_x;
            vox1_reg.y     <= (in_kind == vds_pkg::KIND_FLUSH) ? '0 : in_y;
            vox1_reg.z     <= (in_kind == vds_pkg::KIND_FLUSH) ? '0 : in_z;
            pend_reg.fire_ok <= fire_ok;
            vox2_reg         <= vox1_reg;
            waddr_reg        <= wptr_reg;
            ra_ctr_reg       <= ring_back(wptr_reg, k_ctr);
            ra_nx_reg        <= ring_back(wptr_reg, k_nx);
            ra_ny_reg        <= ring_back(wptr_reg, k_ny);
            ra_py_reg        <= ring_back(wptr_reg, k_py);
            ra_nz_reg        <= ring_back(wptr_reg, k_nz);
            ra_pz_reg        <= ring_back(wptr_reg, k_pz);
        end
    end

    assign pend   = pend_reg;
    assign wr_vox = vox2_reg;
    assign waddr  = waddr_reg;
    assign ra_ctr = ra_ctr_reg;
    assign ra_nx  = ra_nx_reg;
    assign ra_ny  = ra_ny_reg;
    assign ra_py  = ra_py_reg;
    assign ra_nz  = ra_nz_reg;
    assign ra_pz  = ra_pz_reg;

endmodule

### src/vds_diff.sv
// Edge handling, output voxel coordinates and per-axis central differences.
// Depends on vds_pkg.
module vds_diff (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  vds_pkg::pend_t                      pend_in,
    input  vds_pkg::vox_t                       q_ctr,
    input  vds_pkg::vox_t                       q_nx,
    input  logic signed [vds_pkg::SAMPLE_W-1:0] q_ny,
    input  logic signed [vds_pkg::SAMPLE_W-1:0] q_py,
    input  logic signed [vds_pkg::SAMPLE_W-1:0] q_nz,
    input  logic signed [vds_pkg::SAMPLE_W-1:0] q_pz,
    input  vds_pkg::geom_t                      geom,
    output vds_pkg::res_ctl_t                   ctl_out,
    output vds_pkg::diff_t                      diff_out
);

    vds_pkg::pend_t                      pend_reg;
    logic signed [vds_pkg::SAMPLE_W-1:0] prvx_reg;
    logic [vds_pkg::DIM_W-1:0]           col_reg, col_next;
    logic [vds_pkg::DIM_W-1:0]           row_reg, row_next;
    logic [vds_pkg::DEPTH_W-1:0]         plane_reg, plane_next;
    logic                                fire;
    logic                                col_end, row_end, plane_end;
    logic signed [vds_pkg::SAMPLE_W-1:0] x_prev, x_next, y_prev, y_next, z_prev, z_next;
    vds_pkg::diff_t                      diff;
    vds_pkg::res_ctl_t                   ctl_reg;
    vds_pkg::diff_t                      diff_reg;

    assign fire      = pend_reg.valid && pend_reg.fire_ok && q_ctr.voxel;
    assign col_end   = col_reg >= geom.w - 1'b1;
    assign row_end   = row_reg >= geom.h - 1'b1;
    assign plane_end = plane_reg >= geom.d - 1'b1;

    // the center stands in for a neighbor outside the volume
    assign x_prev = (col_reg == '0)   ? q_ctr.x : prvx_reg;
    assign x_next = col_end           ? q_ctr.x : q_nx.x;
    assign y_prev = (row_reg == '0)   ? q_ctr.y : q_py;
    assign y_next = row_end           ? q_ctr.y : q_ny;
    assign z_prev = (plane_reg == '0) ? q_ctr.z : q_pz;
    assign z_next = plane_end         ? q_ctr.z : q_nz;

    always_comb begin
        diff.x = {x_next[vds_pkg::SAMPLE_W-1], x_next} - {x_prev[vds_pkg::SAMPLE_W-1], x_prev};
        diff.y = {y_next[vds_pkg::SAMPLE_W-1], y_next} - {y_prev[vds_pkg::SAMPLE_W-1], y_prev};
        diff.z = {z_next[vds_pkg::SAMPLE_W-1], z_next} - {z_prev[vds_pkg::SAMPLE_W-1], z_prev};
        // drop axes beyond the component count
        if (geom.comps == 2'd0) begin
            diff.x = '0;
        end
        if (geom.comps < 2'd2) begin
            diff.y = '0;
        end
        if (geom.comps != 2'd3) begin
            diff.z = '0;
        end
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (en && fire) begin
            if (col_end) begin
                col_next = '0;
                if (row_end) begin
                    row_next   = '0;
                    plane_next = plane_end ? '0 : plane_reg + 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg.valid <= 1'b0;
            ctl_reg.valid  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            plane_reg      <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            if (en) begin
                pend_reg.valid <= pend_in.valid;
                ctl_reg.valid  <= fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pend_reg.fire_ok <= pend_in.fire_ok;
            ctl_reg.last     <= col_end && row_end && plane_end;
            diff_reg         <= diff;
            // this center is the previous x neighbor of the next beat
            if (pend_reg.valid) begin
                prvx_reg <= q_ctr.x;
            end
        end
    end

    assign ctl_out  = ctl_reg;
    assign diff_out = diff_reg;

endmodule

### src/vds_mac.sv
// Per-axis scale multiplies, registered, and the final three-way sum.
// Depends on vds_pkg.
module vds_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  vds_pkg::res_ctl_t ctl_in,
    input  vds_pkg::diff_t    diff_in,
    input  vds_pkg::scale_t   scale,
    output logic              res_valid,
    output vds_pkg::result_t  res
);

    vds_pkg::res_ctl_t                 ctl_reg;
    logic signed [vds_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg.last <= ctl_in.last;
            prod_x_reg   <= diff_in.x * $signed({1'b0, scale.x});
            prod_y_reg   <= diff_in.y * $signed({1'b0, scale.y});
            prod_z_reg   <= diff_in.z * $signed({1'b0, scale.z});
        end
    end

    assign res_valid = ctl_reg.valid;
    assign res.last  = ctl_reg.last;
    assign res.div   = vds_pkg::DIV_W'(prod_x_reg) + vds_pkg::DIV_W'(prod_y_reg)
                     + vds_pkg::DIV_W'(prod_z_reg);

endmodule

### src/volume_divergence_stencil.sv
// Top level of the central-difference divergence stencil over a 3-D vector volume.
// Depends on vds_pkg, vds_ram, vds_addr, vds_diff and vds_mac.
//
// Voxels enter in raster order (x fastest, then y, then z) at one beat per
// clock; s_tready drops only while the two-entry output buffer is full, so
// the block runs at one beat per cycle whenever the sink keeps up. Each
// beat is written into three history RAMs (a combined center word and the
// y and z components), of 2*W*H+W+2 slots each for the clamped maxima W and
// H; one write and two reads per RAM per cycle fetch six stencil taps per
// beat and a register keeps the previous x. A voxel's divergence is emitted
// when the beat vol_width*vol_height+vol_width+1 positions later enters,
// and passes the input, address, RAM read, difference and multiply stages;
// send flush ticks (tuser high) to push the tail of a volume out. A flush
// tick fills a stream slot with zeros and gives no result of its own. The
// history RAMs start undefined and get no clearing pass; a neighbor at a
// volume edge is replaced by the center value, so only slots already
// written are used. Width and height of 0 count as 1 and values above the
// maxima are clamped; a depth of 0 counts as 1. Change configuration only
// while no results are outstanding. The result is exact in Q.12, with
// m_tlast high on the final voxel of each volume.
module volume_divergence_stencil #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [vds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vds_pkg::CFG_DATA_W-1:0]     cfg_data,
    // voxel stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vds_pkg::TDATA_IN_W-1:0]     s_tdata,  // comp_x, comp_y, comp_z
    input  logic                               s_tuser,  // kind
    // divergence stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vds_pkg::TDATA_OUT_W-1:0]    m_tdata,  // divergence, zero pad
    output logic                               m_tlast
);

    // vol_width and vol_height are 7 bits wide, so nothing above 127 is reachable
    localparam int W_MAX      = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
    localparam int H_MAX      = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int HIST_DEPTH = 2 * W_MAX * H_MAX + W_MAX + 2;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_CAP    = W_MAX * H_MAX + W_MAX + 2;
    localparam int SW         = vds_pkg::SAMPLE_W;

    // configuration registers
    logic [vds_pkg::DIM_W-1:0]   vol_width_reg;
    logic [vds_pkg::DIM_W-1:0]   vol_height_reg;
    logic [vds_pkg::DEPTH_W-1:0] vol_depth_reg;
    logic [vds_pkg::COMP_W-1:0]  comp_count_reg;
    vds_pkg::scale_t             scale_reg;

    vds_pkg::geom_t    geom;
    logic              adv;

    vds_pkg::pend_t    pend;
    vds_pkg::vox_t     wr_vox;
    logic [ADDR_W-1:0] waddr, ra_ctr, ra_nx, ra_ny, ra_py, ra_nz, ra_pz;
    logic              ram_en;
    vds_pkg::vox_t     q_ctr, q_nx;
    logic [SW-1:0]     q_ny, q_py, q_nz, q_pz;

    vds_pkg::res_ctl_t dctl;
    vds_pkg::diff_t    ddiff;
    logic              res_valid;
    vds_pkg::result_t  res;

    // output buffer
    logic [1:0]        ocnt_reg, ocnt_next;
    vds_pkg::result_t  head_reg, head_next;
    vds_pkg::result_t  tail_reg, tail_next;
    logic              push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_width_reg  <= vds_pkg::RST_VOL_WIDTH;
            vol_height_reg <= vds_pkg::RST_VOL_HEIGHT;
            vol_depth_reg  <= vds_pkg::RST_VOL_DEPTH;
            comp_count_reg <= vds_pkg::RST_COMP_COUNT;
            scale_reg.x    <= vds_pkg::RST_SCALE;
            scale_reg.y    <= vds_pkg::RST_SCALE;
            scale_reg.z    <= vds_pkg::RST_SCALE;
        end else if (cfg_wr_en) begin
            case (vds_pkg::reg_idx_t'(cfg_index))
                vds_pkg::REG_VOL_WIDTH: begin
                    vol_width_reg <= cfg_data[vds_pkg::DIM_W-1:0];
                end
                vds_pkg::REG_VOL_HEIGHT: begin
                    vol_height_reg <= cfg_data[vds_pkg::DIM_W-1:0];
                end
                vds_pkg::REG_VOL_DEPTH: begin
                    vol_depth_reg <= cfg_data;
                end
                vds_pkg::REG_COMP_COUNT: begin
                    comp_count_reg <= cfg_data[vds_pkg::COMP_W-1:0];
                end
                vds_pkg::REG_SCALE_X: begin
                    scale_reg.x <= cfg_data;
                end
                vds_pkg::REG_SCALE_Y: begin
                    scale_reg.y <= cfg_data;
                end
                vds_pkg::REG_SCALE_Z: begin
                    scale_reg.z <= cfg_data;
                end
                default: begin
                    // index beyond the register list: drop the write
                end
            endcase
        end
    end

    // clamp geometry into the supported range
    always_comb begin
        if (vol_width_reg == '0) begin
            geom.w = vds_pkg::DIM_W'(1);
        end else if (vol_width_reg > vds_pkg::DIM_W'(W_MAX)) begin
            geom.w = vds_pkg::DIM_W'(W_MAX);
        end else begin
            geom.w = vol_width_reg;
        end
        if (vol_height_reg == '0) begin
            geom.h = vds_pkg::DIM_W'(1);
        end else if (vol_height_reg > vds_pkg::DIM_W'(H_MAX)) begin
            geom.h = vds_pkg::DIM_W'(H_MAX);
        end else begin
            geom.h = vol_height_reg;
        end
        geom.d     = (vol_depth_reg == '0) ? vds_pkg::DEPTH_W'(1) : vol_depth_reg;
        geom.comps = comp_count_reg;
    end

    // the whole pipeline advances unless the output buffer is full
    assign adv      = (ocnt_reg != 2'd2);
    assign s_tready = adv;

    vds_addr #(
        .HIST_DEPTH (HIST_DEPTH),
        .CNT_CAP    (CNT_CAP)
    ) u_addr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_x     (s_tdata[SW-1:0]),
        .in_y     (s_tdata[2*SW-1:SW]),
        .in_z     (s_tdata[3*SW-1:2*SW]),
        .geom     (geom),
        .pend     (pend),
        .wr_vox   (wr_vox),
        .waddr    (waddr),
        .ra_ctr   (ra_ctr),
        .ra_nx    (ra_nx),
        .ra_ny    (ra_ny),
        .ra_py    (ra_py),
        .ra_nz    (ra_nz),
        .ra_pz    (ra_pz)
    );

    // write and read the history only on a moving beat, so read data holds on stall
    assign ram_en = adv && pend.valid;

    // center word on port a, next x neighbor on port b
    vds_ram #(
        .WIDTH ($bits(vds_pkg::vox_t)),
        .DEPTH (HIST_DEPTH)
    ) u_ram_ctr (
        .aclk    (aclk),
        .we      (ram_en),
        .waddr   (waddr),
        .wdata   (wr_vox),
        .re      (ram_en),
        .raddr_a (ra_ctr),
        .raddr_b (ra_nx),
        .rdata_a (q_ctr),
        .rdata_b (q_nx)
    );

    vds_ram #(
        .WIDTH (SW),
        .DEPTH (HIST_DEPTH)
    ) u_ram_y (
        .aclk    (aclk),
        .we      (ram_en),
        .waddr   (waddr),
        .wdata   (wr_vox.y),
        .re      (ram_en),
        .raddr_a (ra_ny),
        .raddr_b (ra_py),
        .rdata_a (q_ny),
        .rdata_b (q_py)
    );

    vds_ram #(
        .WIDTH (SW),
        .DEPTH (HIST_DEPTH)
    ) u_ram_z (
        .aclk    (aclk),
        .we      (ram_en),
        .waddr   (waddr),
        .wdata   (wr_vox.z),
        .re      (ram_en),
        .raddr_a (ra_nz),
        .raddr_b (ra_pz),
        .rdata_a (q_nz),
        .rdata_b (q_pz)
    );

    vds_diff u_diff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .pend_in  (pend),
        .q_ctr    (q_ctr),
        .q_nx     (q_nx),
        .q_ny     (q_ny),
        .q_py     (q_py),
        .q_nz     (q_nz),
        .q_pz     (q_pz),
        .geom     (geom),
        .ctl_out  (dctl),
        .diff_out (ddiff)
    );

    vds_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .ctl_in    (dctl),
        .diff_in   (ddiff),
        .scale     (scale_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // two-entry output buffer: the head drives the master side
    assign push = adv && res_valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        ocnt_next = ocnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        case ({push, pop})
            2'b10: begin
                if (ocnt_reg == 2'd0) begin
                    head_next = res;
                end else begin
                    tail_next = res;
                end
                ocnt_next = ocnt_reg + 2'd1;
            end
            2'b01: begin
                head_next = tail_reg;
                ocnt_next = ocnt_reg - 2'd1;
            end
            2'b11: begin
                if (ocnt_reg == 2'd1) begin
                    head_next = res;
                end else begin
                    head_next = tail_reg;
                    tail_next = res;
                end
            end
            default: begin
                ocnt_next = ocnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= 2'd0;
        end else begin
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = {{(vds_pkg::TDATA_OUT_W - vds_pkg::DIV_W){1'b0}}, head_reg.div};
    assign m_tlast  = head_reg.last;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for volume_divergence_stencil: streams vector volumes in raster order,
// predicts every divergence beat in SystemVerilog and compares it against m_tdata/m_tlast.
// Depends on vds_pkg and the RTL under src.
module testbench;

    import vds_pkg::*;

    localparam int MAX_W       = 64;
    localparam int MAX_H       = 64;
    // ring of past samples, same span as the block keeps
    localparam int HIST        = 2 * MAX_W * MAX_H + MAX_W + 2;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 600;
    localparam logic KIND_VOXEL = ~KIND_FLUSH;

    typedef struct packed {
        logic        kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } beat_t;

    typedef struct packed {
        logic signed [DIV_W-1:0] div;
        logic                    last;
    } div_result_t;

    // DUT ports, inputs driven from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;  // comp_x, comp_y, comp_z
    logic                   s_tuser   = 1'b0; // kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;          // divergence, zero pad
    logic                   m_tlast;

    volume_divergence_stencil dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the register file, reset values
    logic [6:0]  sh_width  = 7'd64;
    logic [6:0]  sh_height = 7'd64;
    logic [15:0] sh_depth  = 16'd64;
    logic [1:0]  sh_comps  = 2'd3;
    logic [15:0] sh_sx     = 16'd2048;
    logic [15:0] sh_sy     = 16'd2048;
    logic [15:0] sh_sz     = 16'd2048;

    // Predictor state: sample ring, voxel flags, input count, output coordinates
    logic [15:0] ring_x [HIST];
    logic [15:0] ring_y [HIST];
    logic [15:0] ring_z [HIST];
    bit          ring_voxel [HIST];
    int unsigned taken_count = 0;
    int unsigned ring_wr     = 0;
    int unsigned at_col      = 0;
    int unsigned at_row      = 0;
    int unsigned at_plane    = 0;

    div_result_t div_expected [$];
    beat_t       pending [$];

    bit          idle_en     = 1'b1;
    int unsigned guard_lag   = HIST;  // trailing flushes known to sit behind the write point
    int unsigned phase_lag   = 0;
    int unsigned send_gap    = 0;
    int unsigned hold_left   = 0;
    int unsigned quiet       = 0;
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned mismatches  = 0;
    int unsigned volumes_run = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int sample_at(input int axis, input int unsigned slot);
        if (axis == 0) return int'($signed(ring_x[slot]));
        if (axis == 1) return int'($signed(ring_y[slot]));
        return int'($signed(ring_z[slot]));
    endfunction

    // Advance the stencil by one accepted beat; queue the divergence it releases, if any.
    task automatic predict_divergence(input logic kind, input logic [15:0] cx,
                                      input logic [15:0] cy, input logic [15:0] cz);
        int unsigned w, h, d, lag, ctr_slot;
        int unsigned stride [3];
        int unsigned pos [3];
        int unsigned ext [3];
        int unsigned scl [3];
        longint      acc;
        int          ctr, prv, nxt;
        div_result_t r;
        w = clamp_dim(sh_width, MAX_W);
        h = clamp_dim(sh_height, MAX_H);
        d = (sh_depth == 0) ? 1 : sh_depth;
        lag = w * h + w + 1;

        // a flush tick occupies the slot as an all-zero non-voxel
        if (kind == KIND_FLUSH) begin
            ring_x[ring_wr] = '0;
            ring_y[ring_wr] = '0;
            ring_z[ring_wr] = '0;
            ring_voxel[ring_wr] = 1'b0;
        end else begin
            ring_x[ring_wr] = cx;
            ring_y[ring_wr] = cy;
            ring_z[ring_wr] = cz;
            ring_voxel[ring_wr] = 1'b1;
        end
        ring_wr = (ring_wr + 1) % HIST;
        if (taken_count != 32'hFFFF_FFFF) taken_count++;

        if (taken_count <= lag) return;
        ctr_slot = (ring_wr + HIST - 1 - lag) % HIST;
        if (!ring_voxel[ctr_slot]) return;

        stride[0] = 1;        stride[1] = w;       stride[2] = w * h;
        pos[0]    = at_col;   pos[1]    = at_row;  pos[2]    = at_plane;
        ext[0]    = w;        ext[1]    = h;       ext[2]    = d;
        scl[0]    = sh_sx;    scl[1]    = sh_sy;   scl[2]    = sh_sz;

        acc = 0;
        for (int a = 0; a < 3 && a < int'(sh_comps); a++) begin
            ctr = sample_at(a, ctr_slot);
            // at a volume edge the center stands in for the missing neighbor
            prv = (pos[a] == 0) ? ctr : sample_at(a, (ctr_slot + HIST - stride[a]) % HIST);
            nxt = (pos[a] >= ext[a] - 1) ? ctr : sample_at(a, (ctr_slot + stride[a]) % HIST);
            acc += longint'(nxt - prv) * longint'(scl[a]);
        end

        r.div  = acc[DIV_W-1:0];
        r.last = (at_col >= w - 1) && (at_row >= h - 1) && (at_plane >= d - 1);
        div_expected.push_back(r);

        // step output coordinates in raster order, wrapping at each extent
        if (at_col >= w - 1) begin
            at_col = 0;
            if (at_row >= h - 1) begin
                at_row = 0;
                if (at_plane >= d - 1) at_plane = 0;
                else at_plane++;
            end else begin
                at_row++;
            end
        end else begin
            at_col++;
        end
    endtask

    // Driver: present queued beats, hold until accepted, insert random gaps.
    always @(posedge aclk) begin : drive_beats
        beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_divergence(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    nb = pending.pop_front();
                    s_tdata  <= {nb.z, nb.y, nb.x};
                    s_tuser  <= nb.kind;
                    s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted divergence beat against the oldest prediction.
    always @(posedge aclk) begin : check_results
        div_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (div_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected beat: div=%0d last=%0b", $realtime,
                                 $signed(m_tdata[DIV_W-1:0]), m_tlast);
                end else begin
                    want = div_expected.pop_front();
                    if (m_tdata[DIV_W-1:0] !== want.div || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: div exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, want.div, $signed(m_tdata[DIV_W-1:0]),
                                     want.last, m_tlast);
                    end
                end
            end
            // receiver stalls in random bursts, started only while idle_en is set
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_VOL_WIDTH:  sh_width  = val[6:0];
            REG_VOL_HEIGHT: sh_height = val[6:0];
            REG_VOL_DEPTH:  sh_depth  = val;
            REG_COMP_COUNT: sh_comps  = val[1:0];
            REG_SCALE_X:    sh_sx     = val;
            REG_SCALE_Y:    sh_sy     = val;
            REG_SCALE_Z:    sh_sz     = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every beat is sent and every divergence is back, then let the pipe settle.
    task automatic drain();
        while (pending.size() != 0 || s_tvalid || div_expected.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic push_flushes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) pending.push_back('{KIND_FLUSH, 16'h0, 16'h0, 16'h0});
    endtask

    task automatic push_voxel(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        pending.push_back('{KIND_VOXEL, x, y, z});
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Reprogram the geometry between volumes. Make sure the slots the new lag reaches
    // back to are flush ticks, so no old voxel is released twice.
    task automatic start_volume(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] d, input logic [15:0] comps,
                                input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] sz, output int unsigned nvox);
        int unsigned we, he, de, lag;
        we  = clamp_dim(w[6:0], MAX_W);
        he  = clamp_dim(h[6:0], MAX_H);
        de  = (d == 0) ? 1 : d;
        lag = we * he + we + 1;
        if (lag > guard_lag) push_flushes(lag - guard_lag);
        drain();
        write_reg(REG_VOL_WIDTH,  w);
        write_reg(REG_VOL_HEIGHT, h);
        write_reg(REG_VOL_DEPTH,  d);
        write_reg(REG_COMP_COUNT, comps);
        write_reg(REG_SCALE_X,    sx);
        write_reg(REG_SCALE_Y,    sy);
        write_reg(REG_SCALE_Z,    sz);
        phase_lag = lag;
        nvox = we * he * de;
        volumes_run++;
    endtask

    // Push the tail of the volume out with one flush per lag position.
    task automatic end_volume();
        push_flushes(phase_lag);
        guard_lag = phase_lag;
    endtask

    initial begin : stimulus
        int unsigned nvox, rand_items, pick, flush_pct;
        logic [15:0] gw, gh, gd, gc;
        rand_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // single voxel: every axis on both edges, so the result is zero
        start_volume(16'd1, 16'd1, 16'd1, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, nvox);
        push_voxel(16'h7FFF, 16'h8000, 16'h7FFF);
        end_volume();

        // 2x2x2 with full-swing components and maximum scales; flush tick mid-volume
        start_volume(16'd2, 16'd2, 16'd2, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, nvox);
        for (int i = 0; i < 8; i++) begin
            push_voxel((i % 2) ? 16'h7FFF : 16'h8000,
                       ((i / 2) % 2) ? 16'h7FFF : 16'h8000,
                       (i / 4) ? 16'h8000 : 16'h7FFF);
            if (i == 3) push_flushes(1);
        end
        end_volume();

        // zero geometry counts as one, zero components gives zero divergence
        start_volume(16'd0, 16'd0, 16'd0, 16'd0, 16'h1234, 16'hFFFF, 16'h0001, nvox);
        push_voxel(16'h7FFF, 16'h8000, 16'h5A5A);
        end_volume();

        // x only along a row
        start_volume(16'd3, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'h0000, 16'h0000, nvox);
        push_voxel(16'h8000, 16'h7FFF, 16'h7FFF);
        push_voxel(16'h0000, 16'h8000, 16'h8000);
        push_voxel(16'h7FFF, 16'h0000, 16'h0000);
        end_volume();

        // x and y along a column
        start_volume(16'd1, 16'd3, 16'd1, 16'd2, 16'h0000, 16'h1000, 16'hFFFF, nvox);
        push_voxel(16'h7FFF, 16'h8000, 16'h7FFF);
        push_voxel(16'h8000, 16'h0001, 16'h8000);
        push_voxel(16'h0001, 16'h7FFF, 16'h1234);
        end_volume();

        // deepest volume, only its first planes; the next volume re-syncs the plane count
        start_volume(16'd1, 16'd1, 16'hFFFF, 16'd3, 16'h0800, 16'h0800, 16'h0800, nvox);
        repeat (8) push_voxel(pick_sample(), pick_sample(), pick_sample());
        end_volume();

        start_volume(16'd2, 16'd1, 16'd1, 16'd3, 16'h0800, 16'h0800, 16'h0800, nvox);
        repeat (nvox) push_voxel(pick_sample(), pick_sample(), pick_sample());
        end_volume();

        // widest and tallest plane, over-range values clamp to the maxima
        start_volume(16'd127, 16'd127, 16'd1, 16'd3, pick_scale(), pick_scale(),
                     pick_scale(), nvox);
        repeat (nvox) push_voxel(16'($urandom), 16'($urandom), 16'($urandom));
        end_volume();

        // random volumes, mostly small, occasionally long rows or columns
        while (rand_items < RAND_ITEMS) begin
            // no idling in the closing stretch
            if (rand_items >= RAND_ITEMS - 120) idle_en = 1'b0;
            else idle_en = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    gw = 16'd64;
                    gh = 16'($urandom_range(1, 2));
                    gd = 16'd1;
                end
                1: begin
                    gw = 16'($urandom_range(1, 2));
                    gh = 16'($urandom_range(64, 127));
                    gd = 16'd1;
                end
                2: begin
                    gw = 16'($urandom_range(65, 127));
                    gh = 16'($urandom_range(0, 1));
                    gd = 16'($urandom_range(0, 1));
                end
                default: begin
                    gw = 16'($urandom_range(1, 6));
                    gh = 16'($urandom_range(1, 6));
                    gd = 16'($urandom_range(0, 4));
                end
            endcase
            gc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2)) : 16'd3;
            flush_pct = ($urandom_range(0, 2) == 0) ? 6 : 0;
            start_volume(gw, gh, gd, gc, pick_scale(), pick_scale(), pick_scale(), nvox);
            for (int unsigned i = 0; i < nvox; i++) begin
                // stray flush ticks inside the volume
                if ($urandom_range(0, 99) < flush_pct) push_flushes(1);
                push_voxel(pick_sample(), pick_sample(), pick_sample());
            end
            end_volume();
            rand_items += nvox;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (div_expected.size() != 0) mismatches += div_expected.size();

        $display("summary: %0d volume setups, %0d beats in, %0d divergence beats checked",
                 volumes_run, beats_in, beats_out);
        $display("summary: %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
